// ===== rtl/v3a_pkg.sv =====
package v3a_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned Lanes    = 3;

  typedef enum logic [2:0] {
    OP_SUM   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DOT   = 3'd3,
    OP_MAG2  = 3'd4,
    OP_MAG   = 3'd5,
    OP_NORM  = 3'd6,
    OP_REFL  = 3'd7
  } op_e;

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] prod_t;

  // Pipeline control that travels beside the lanes.
  typedef struct packed {
    logic valid;
    op_e  op;
  } ctl_t;

  function automatic q_t sat32(input logic signed [67:0] v, output logic ovf);
    ovf = 1'b0;
    if (v > 68'sd2147483647) begin
      ovf = 1'b1;
      sat32 = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      ovf = 1'b1;
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== rtl/v3a_sqrt.sv =====
// Pipelined restoring square root of a 66-bit value, two result bits per stage.
module v3a_sqrt import v3a_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [65:0] rad_i,
  output logic [32:0] root_o
);

  localparam int unsigned Steps = 33;
  localparam int unsigned PerStage = 2;
  localparam int unsigned Stages = (Steps + PerStage - 1) / PerStage;

  logic [65:0] rem_q  [Stages+1];
  logic [65:0] rad_q  [Stages+1];
  logic [32:0] root_q [Stages+1];

  assign rem_q[0]  = '0;
  assign rad_q[0]  = rad_i;
  assign root_q[0] = '0;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [65:0] rem_d, rad_d;
    logic [32:0] root_d;
    always_comb begin
      logic [67:0] trial;
      rem_d  = rem_q[s];
      rad_d  = rad_q[s];
      root_d = root_q[s];
      for (int k = 0; k < PerStage; k++) begin
        if (s * PerStage + k < Steps) begin
          rem_d = {rem_d[63:0], rad_d[65:64]};
          rad_d = {rad_d[63:0], 2'b00};
          trial = {2'b00, rem_d} - {33'd0, root_d, 2'b01};
          if (!trial[67]) begin
            rem_d  = trial[65:0];
            root_d = {root_d[31:0], 1'b1};
          end else begin
            root_d = {root_d[31:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_d;
        rad_q[s+1]  <= rad_d;
        root_q[s+1] <= root_d;
      end
    end
  end

  assign root_o = root_q[Stages];

endmodule

// ===== rtl/v3a_div.sv =====
// Pipelined signed division of a 48-bit numerator by a 33-bit positive magnitude,
// truncated toward zero, one quotient bit per step, four steps per stage.
module v3a_div import v3a_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] num_i,
  input  logic [32:0]        den_i,
  output logic signed [67:0] quo_o
);

  localparam int unsigned NumBits = 32 + FracBits;
  localparam int unsigned PerStage = 4;
  localparam int unsigned Stages = (NumBits + PerStage - 1) / PerStage;

  logic [NumBits-1:0] n_q   [Stages+1];
  logic [33:0]        r_q   [Stages+1];
  logic [32:0]        d_q   [Stages+1];
  logic               neg_q [Stages+1];

  logic [31:0] mag_a;
  assign mag_a = num_i[31] ? 32'(-num_i) : num_i;
  assign n_q[0]   = {mag_a, {FracBits{1'b0}}};
  assign r_q[0]   = '0;
  assign d_q[0]   = den_i;
  assign neg_q[0] = num_i[31];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [NumBits-1:0] n_d;
    logic [33:0] r_d;
    always_comb begin
      logic [34:0] t;
      n_d = n_q[s];
      r_d = r_q[s];
      for (int k = 0; k < PerStage; k++) begin
        if (s * PerStage + k < NumBits) begin
          r_d = {r_d[32:0], n_d[NumBits-1]};
          t   = {1'b0, r_d} - {2'b00, d_q[s]};
          n_d = {n_d[NumBits-2:0], ~t[34]};
          if (!t[34]) r_d = t[33:0];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s+1]   <= n_d;
        r_q[s+1]   <= r_d;
        d_q[s+1]   <= d_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  logic signed [67:0] q_ext;
  assign q_ext = $signed({{(68-NumBits){1'b0}}, n_q[Stages]});
  assign quo_o = neg_q[Stages] ? -q_ext : q_ext;

endmodule

// ===== rtl/v3a_lane.sv =====
// One component lane: multiplier products and simple sums for one axis.
module v3a_lane import v3a_pkg::*; (
  input  logic         clk_i,
  input  logic         en_i,
  input  op_e          op_i,
  input  q_t           a_i,
  input  q_t           b_i,
  input  q_t           scale_i,
  output prod_t        prod_o,
  output logic signed [32:0] sum_o
);

  q_t mul_b;
  always_comb begin
    case (op_i)
      OP_SCALE:                  mul_b = scale_i;
      OP_MAG2, OP_MAG, OP_NORM:  mul_b = a_i;
      default:                   mul_b = b_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= a_i * mul_b;
      sum_o  <= (op_i == OP_SUB) ? 33'(a_i) - 33'(b_i) : 33'(a_i) + 33'(b_i);
    end
  end

endmodule

// ===== rtl/vec3_fixed_point_alu.sv =====
// Three-component Q16.16 vector ALU. One operation word is accepted every cycle
// unless a result word waits at the output under out_stall_i. Every word passes 33
// register stages: two for the lane products and their merge, 17 for the pipelined
// square root, 12 for the divider used for normalize, one for reflection and
// saturation, and the output register. The accepting edge loads the first of them,
// and every mode passes the same registers, so results leave in order. Three lanes
// form the per-axis products, an adder tree merges them for dot and magnitude, and
// a shared stage applies reflection and saturation. The whole pipeline advances
// only when the output register is free, so a stall freezes it.
module vec3_fixed_point_alu import v3a_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  q_t          a_x_i,
  input  q_t          a_y_i,
  input  q_t          a_z_i,
  input  q_t          b_x_i,
  input  q_t          b_y_i,
  input  q_t          b_z_i,
  input  q_t          scale_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output q_t          r_x_o,
  output q_t          r_y_o,
  output q_t          r_z_o,
  output q_t          r_scalar_o,
  output logic        overflow_o,
  output logic        zero_length_o
);

  localparam int unsigned SqrtLat = (33 + 1) / 2;
  localparam int unsigned DivLat  = (32 + FracBits + 3) / 4;
  // Stage 1 lanes, 2 merge, 3 sqrt, then divider, then final stage.
  localparam int unsigned Depth   = 2 + SqrtLat + DivLat + 1;

  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  q_t a [Lanes];
  q_t b [Lanes];
  assign a[0] = a_x_i; assign a[1] = a_y_i; assign a[2] = a_z_i;
  assign b[0] = b_x_i; assign b[1] = b_y_i; assign b[2] = b_z_i;

  // Stage 1: lanes.
  prod_t prod [Lanes];
  logic signed [32:0] sum [Lanes];
  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    v3a_lane u_lane (
      .clk_i, .en_i(en), .op_i(op_e'(mode_i)), .a_i(a[l]), .b_i(b[l]),
      .scale_i, .prod_o(prod[l]), .sum_o(sum[l])
    );
  end

  // Side delay lines for control and operands.
  ctl_t ctl_q  [Depth+1];
  q_t   ax_q   [Depth+1][Lanes];
  q_t   bx_q   [Depth+1][Lanes];
  assign ctl_q[0] = '{valid: in_valid_i, op: op_e'(mode_i)};
  for (genvar l = 0; l < Lanes; l++) begin : g_tap0
    assign ax_q[0][l] = a[l];
    assign bx_q[0][l] = b[l];
  end
  for (genvar s = 0; s < Depth; s++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) ctl_q[s+1] <= '0;
      else if (en) ctl_q[s+1] <= ctl_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        ax_q[s+1] <= ax_q[s];
        bx_q[s+1] <= bx_q[s];
      end
    end
  end

  // Stage 2: merge of the lane products, exact, then floored.
  logic signed [65:0] dot_q;
  prod_t prod_q [Lanes];
  logic signed [32:0] sum_q [Lanes];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dot_q  <= 66'(prod[0]) + 66'(prod[1]) + 66'(prod[2]);
      prod_q <= prod;
      sum_q  <= sum;
    end
  end

  // Square root runs on the exact sum of squares; it is nonnegative.
  logic [32:0] root;
  v3a_sqrt u_sqrt (
    .clk_i, .en_i(en), .rad_i(dot_q[65:0]), .root_o(root)
  );

  // Values waiting for the end of the pipe, carried from stage 2.
  localparam int unsigned Wait = SqrtLat + DivLat;
  logic signed [65:0] dotw_q [Wait+1];
  prod_t prodw_q [Wait+1][Lanes];
  logic signed [32:0] sumw_q [Wait+1][Lanes];
  logic [32:0] rootw_q [DivLat+1];
  assign dotw_q[0]  = dot_q;
  assign prodw_q[0] = prod_q;
  assign sumw_q[0]  = sum_q;
  assign rootw_q[0] = root;
  for (genvar s = 0; s < Wait; s++) begin : g_wait
    always_ff @(posedge clk_i) begin
      if (en) begin
        dotw_q[s+1]  <= dotw_q[s];
        prodw_q[s+1] <= prodw_q[s];
        sumw_q[s+1]  <= sumw_q[s];
      end
    end
  end
  for (genvar s = 0; s < DivLat; s++) begin : g_rw
    always_ff @(posedge clk_i) begin
      if (en) rootw_q[s+1] <= rootw_q[s];
    end
  end

  // Divider lanes for normalize.
  logic signed [67:0] quo [Lanes];
  logic [32:0] den;
  assign den = (root == '0) ? 33'd1 : root;
  for (genvar l = 0; l < Lanes; l++) begin : g_div
    v3a_div u_div (
      .clk_i, .en_i(en), .num_i(ax_q[2 + SqrtLat][l]), .den_i(den), .quo_o(quo[l])
    );
  end

  // Reflection: doubled dot is saturated, then lanes multiply by it and both are registered.
  localparam int unsigned Fin = 2 + Wait;
  logic signed [65:0] dfl;
  logic d2_ovf, d2_ovf_q;
  q_t d2, d2_q;
  always_comb begin
    dfl = dotw_q[Wait] >>> FracBits;
    d2  = sat32(68'(dfl) * 68'sd2, d2_ovf);
  end
  prod_t bd_q [Lanes];
  logic signed [65:0] dotf_q;
  logic [32:0] rootf_q;
  logic signed [67:0] quo_q [Lanes];
  logic signed [32:0] sumf_q [Lanes];
  prod_t prodf_q [Lanes];
  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q     <= d2;
      d2_ovf_q <= d2_ovf;
      for (int l = 0; l < Lanes; l++) bd_q[l] <= bx_q[Fin][l] * d2;
      dotf_q   <= dfl;
      rootf_q  <= rootw_q[DivLat];
      quo_q    <= quo;
      sumf_q   <= sumw_q[Wait];
      prodf_q  <= prodw_q[Wait];
    end
  end

  // Final stage into the output register.
  q_t   rv_d [Lanes];
  q_t   rs_d;
  logic ovf_d, zl_d;
  always_comb begin
    logic o;
    logic signed [67:0] t;
    o     = 1'b0;
    t     = '0;
    ovf_d = 1'b0;
    zl_d  = 1'b0;
    rs_d  = '0;
    for (int l = 0; l < Lanes; l++) rv_d[l] = '0;
    unique case (ctl_q[Depth].op) inside
      OP_SUM, OP_SUB: begin
        for (int l = 0; l < Lanes; l++) begin
          rv_d[l] = sat32(68'(sumf_q[l]), o);
          ovf_d |= o;
        end
      end
      OP_SCALE: begin
        for (int l = 0; l < Lanes; l++) begin
          rv_d[l] = sat32(68'(prodf_q[l] >>> FracBits), o);
          ovf_d |= o;
        end
      end
      OP_DOT, OP_MAG2: begin
        rs_d  = sat32(68'(dotf_q), o);
        ovf_d = o;
      end
      OP_MAG: begin
        rs_d  = sat32($signed({35'd0, rootf_q}), o);
        ovf_d = o;
      end
      OP_NORM: begin
        if (rootf_q == '0) zl_d = 1'b1;
        else begin
          for (int l = 0; l < Lanes; l++) begin
            rv_d[l] = sat32(quo_q[l], o);
            ovf_d |= o;
          end
        end
      end
      OP_REFL: begin
        ovf_d = d2_ovf_q;
        for (int l = 0; l < Lanes; l++) begin
          t = 68'(ax_q[Depth][l]) - 68'(bd_q[l] >>> FracBits);
          rv_d[l] = sat32(t, o);
          ovf_d |= o;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= ctl_q[Depth].valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_x_o         <= rv_d[0];
      r_y_o         <= rv_d[1];
      r_z_o         <= rv_d[2];
      r_scalar_o    <= rs_d;
      overflow_o    <= ovf_d;
      zero_length_o <= zl_d;
    end
  end

  // A stalled output keeps the input stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output stalled");

  // A held result keeps its x component and its scalar unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(r_x_o) && $stable(r_scalar_o))
    else $error("held result changed");

  // Zero length is only ever reported with no overflow and no scalar.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |-> !overflow_o && r_scalar_o == '0)
    else $error("zero length with other results");

endmodule

// ===== tb/sv/tb_vec3_fixed_point_alu.sv =====
module tb_vec3_fixed_point_alu;
  import v3a_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    q_t   r_x;
    q_t   r_y;
    q_t   r_z;
    q_t   r_scalar;
    logic overflow;
    logic zero_length;
  } vec_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] mode_i;
  q_t         a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, scale_i;
  logic       out_valid_o;
  logic       out_stall_i;
  q_t         r_x_o, r_y_o, r_z_o, r_scalar_o;
  logic       overflow_o;
  logic       zero_length_o;

  vec_result_t pending_results[$];
  int unsigned mismatch_count;
  bit          hold_off_req;
  bit          hold_off_active;
  bit          random_stall_on;

  vec3_fixed_point_alu u_dut (.*);

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #200ms;
    $display("[vec3_fixed_point_alu] ERROR");
    $finish;
  end

  // Floor shift on a wide signed value.
  function automatic logic signed [127:0] floor_shift(input logic signed [127:0] v);
    floor_shift = v >>> FracBits;
  endfunction

  function automatic logic signed [127:0] clamp_q(input logic signed [127:0] v,
                                                  inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      clamp_q = 128'sd2147483647;
    end else if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      clamp_q = -128'sd2147483648;
    end else begin
      clamp_q = v;
    end
  endfunction

  // The exact product sum floored once equals the per-product floor sum plus
  // the floor of the summed remainders.
  function automatic logic signed [127:0] dot_floored(input q_t u[3], input q_t w[3]);
    logic signed [127:0] acc;
    acc = 0;
    for (int i = 0; i < 3; i++) acc += 128'(signed'(u[i])) * 128'(signed'(w[i]));
    dot_floored = floor_shift(acc);
  endfunction

  function automatic logic [127:0] root_floor(input logic [127:0] n);
    logic [127:0] res, bitv;
    res = 0;
    bitv = 128'd1 << 66;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    root_floor = res;
  endfunction

  function automatic vec_result_t predict_vec_op(input logic [2:0] mode, input q_t a[3],
                                                input q_t b[3], input q_t sc);
    vec_result_t         res;
    logic                ovf;
    logic signed [127:0] r[3];
    logic signed [127:0] scalar, d2, mag, sq;
    ovf = 1'b0;
    scalar = 0;
    res.zero_length = 1'b0;
    for (int i = 0; i < 3; i++) r[i] = 0;
    case (op_e'(mode)) inside
      OP_SUM: for (int i = 0; i < 3; i++)
        r[i] = clamp_q(128'(a[i]) + 128'(b[i]), ovf);
      OP_SUB: for (int i = 0; i < 3; i++)
        r[i] = clamp_q(128'(a[i]) - 128'(b[i]), ovf);
      OP_SCALE: for (int i = 0; i < 3; i++)
        r[i] = clamp_q(floor_shift(128'(a[i]) * 128'(sc)), ovf);
      OP_DOT: scalar = clamp_q(dot_floored(a, b), ovf);
      OP_MAG2: scalar = clamp_q(dot_floored(a, a), ovf);
      OP_MAG, OP_NORM: begin
        // The sum of squares wraps at 64 bits, as an unsigned accumulator does.
        sq = 0;
        for (int i = 0; i < 3; i++) sq += 128'(a[i]) * 128'(a[i]);
        mag = root_floor(128'(sq[63:0]));
        if (op_e'(mode) == OP_MAG) begin
          scalar = clamp_q(mag, ovf);
        end else if (mag == 0) begin
          res.zero_length = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++)
            r[i] = clamp_q((128'(a[i]) <<< FracBits) / mag, ovf);
        end
      end
      default: begin
        d2 = clamp_q(2 * dot_floored(a, b), ovf);
        for (int i = 0; i < 3; i++)
          r[i] = clamp_q(128'(a[i]) - floor_shift(128'(b[i]) * d2), ovf);
      end
    endcase
    res.r_x = r[0][31:0];
    res.r_y = r[1][31:0];
    res.r_z = r[2][31:0];
    res.r_scalar = scalar[31:0];
    res.overflow = ovf;
    predict_vec_op = res;
  endfunction

  task automatic send_word(input logic [2:0] mode, input q_t a[3], input q_t b[3],
                           input q_t sc);
    int unsigned gap;
    gap = $urandom_range(3) == 0 ? 0 : $urandom_range(17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    a_x_i <= a[0];
    a_y_i <= a[1];
    a_z_i <= a[2];
    b_x_i <= b[0];
    b_y_i <= b[1];
    b_z_i <= b[2];
    scale_i <= sc;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_vec_op(mode, a, b, sc));
  endtask

  function automatic q_t rand_q();
    case ($urandom_range(5))
      0: rand_q = $urandom;
      1: rand_q = 32'(signed'($urandom_range(131072))) - 65536;
      2: rand_q = 32'(signed'($urandom_range(16777216))) - 8388608;
      3: rand_q = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      4: rand_q = 32'(signed'($urandom_range(8))) - 4;
      default: rand_q = 32'(signed'($urandom_range(2000000))) - 1000000;
    endcase
  endfunction

  task automatic test_directed();
    q_t a[3], b[3], z[3], mx[3], mn[3];
    z = '{0, 0, 0};
    mx = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    mn = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    a = '{32'sh00010000, 32'sh00020000, -32'sh00030000};
    b = '{32'sh00008000, -32'sh00010000, 32'sh00000001};
    for (int m = 0; m < 8; m++) send_word(m[2:0], a, b, 32'sh00018000);
    send_word(OP_SUM, mx, mx, 0);
    send_word(OP_SUB, mn, mx, 0);
    send_word(OP_SCALE, mn, z, 32'sh80000000);
    send_word(OP_SCALE, a, z, -32'sh00000001);
    send_word(OP_DOT, mx, mx, 0);
    send_word(OP_DOT, mn, mx, 0);
    send_word(OP_MAG2, mn, z, 0);
    send_word(OP_MAG, mn, z, 0);
    send_word(OP_MAG, mx, z, 0);
    send_word(OP_NORM, z, z, 0);
    send_word(OP_NORM, mn, z, 0);
    send_word(OP_NORM, '{1, 0, 0}, z, 0);
    send_word(OP_REFL, mx, mx, 0);
    send_word(OP_REFL, a, z, 0);
  endtask

  task automatic test_random(input int unsigned count);
    q_t a[3], b[3];
    for (int unsigned n = 0; n < count; n++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = rand_q();
        b[i] = rand_q();
      end
      send_word(3'($urandom_range(7)), a, b, rand_q());
    end
  endtask

  // The sender keeps offering words while the receiver is held off.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    fork
      test_random(120);
      begin
        wait (hold_off_active);
        wait (!hold_off_active);
      end
    join
  endtask

  task automatic drain();
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_off_req && !hold_off_active) begin
      hold_off_active <= 1'b1;
      hold_off_req <= 1'b0;
    end
  end

  initial begin
    int unsigned wait_cycles;
    out_stall_i <= 1'b0;
    hold_off_active = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_active) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off_active <= 1'b0;
        out_stall_i <= 1'b0;
      end else if (random_stall_on && $urandom_range(3) == 0) begin
        wait_cycles = $urandom_range(17);
        if (wait_cycles != 0) begin
          out_stall_i <= 1'b1;
          repeat (wait_cycles) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    vec_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        want = pending_results.pop_front();
        if (r_x_o !== want.r_x || r_y_o !== want.r_y || r_z_o !== want.r_z ||
            r_scalar_o !== want.r_scalar || overflow_o !== want.overflow ||
            zero_length_o !== want.zero_length) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp %h %h %h %h ovf %b zl %b, got %h %h %h %h ovf %b zl %b",
                     want.r_x, want.r_y, want.r_z, want.r_scalar, want.overflow,
                     want.zero_length, r_x_o, r_y_o, r_z_o, r_scalar_o, overflow_o,
                     zero_length_o);
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    hold_off_req = 1'b0;
    random_stall_on = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = '0;
    a_x_i = '0;
    a_y_i = '0;
    a_z_i = '0;
    b_x_i = '0;
    b_y_i = '0;
    b_z_i = '0;
    scale_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    random_stall_on = 1'b1;
    test_random(700);
    random_stall_on = 1'b0;
    test_random(300);
    test_backpressure();
    random_stall_on = 1'b1;
    test_random(450);
    drain();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[vec3_fixed_point_alu] OK");
    end else begin
      $display("[vec3_fixed_point_alu] ERROR");
    end
    $finish;
  end

endmodule
